// File: hw/rtl/pwm_brightness_ramp_macros.svh
// assertion macros for the pwm brightness ramp block
// used by the top level only; checks compile out when SYNTHESIS is defined
`ifndef PWM_BRIGHTNESS_RAMP_MACROS_SVH
`define PWM_BRIGHTNESS_RAMP_MACROS_SVH

`ifndef SYNTHESIS

// property that must hold at every clock edge out of reset
`define PBR_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("pwm_brightness_ramp check failed");

// implication checked at every clock edge out of reset
`define PBR_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pwm_brightness_ramp check failed");

`else

`define PBR_ASSERT(lbl, prop)
`define PBR_ASSERT_IMPL(lbl, ante, cons)

`endif

`endif

// File: hw/rtl/pbr_pkg.sv
// shared types and constants for the pwm brightness ramp block
// no dependencies; used by pbr_div, pbr_duty_ram and pwm_brightness_ramp
package pbr_pkg;

    // default sizes
    localparam int LEVELS_DEF    = 256;
    localparam int DUTY_BITS_DEF = 16;

    // fixed field widths
    localparam int LVL_W    = 8;
    localparam int DUR_W    = 16;
    localparam int FS_W     = 16;
    localparam int PERIOD_W = 20;
    localparam int PROD_W   = FS_W + PERIOD_W;

    // register reset values
    localparam logic [PERIOD_W-1:0] PERIOD_RESET = 20'd200000;
    localparam logic [FS_W-1:0]     FS_RESET     = 16'd65535;

    // command codes
    localparam logic [2:0] CMD_TICK  = 3'd0;
    localparam logic [2:0] CMD_START = 3'd1;
    localparam logic [2:0] CMD_STOP  = 3'd2;
    localparam logic [2:0] CMD_SET   = 3'd3;
    localparam logic [2:0] CMD_WRITE = 3'd4;

    // configuration register indexes
    localparam logic CFG_PERIOD     = 1'b0;
    localparam logic CFG_FULL_SCALE = 1'b1;

    // shared divider: 16-bit divisor, up to 20 quotient bits
    localparam int DIV_CNT_W = 5;
    localparam logic [DIV_CNT_W-1:0] DELAY_STEPS = 5'd16;
    localparam logic [DIV_CNT_W-1:0] PULSE_STEPS = 5'd20;

    typedef struct packed {
        logic                 go;
        logic [FS_W-1:0]      rem_init;
        logic [PERIOD_W-1:0]  dividend;
        logic [FS_W-1:0]      divisor;
        logic [DIV_CNT_W-1:0] steps;
    } div_cmd_t;

endpackage

// File: hw/rtl/pbr_div.sv
// shared restoring divider, one quotient bit per cycle
// depends on pbr_pkg for the command struct and widths
module pbr_div (
    input  logic                             clk,
    input  logic                             rst_n,
    input  pbr_pkg::div_cmd_t                cmd,
    output logic                             done,
    output logic [pbr_pkg::PERIOD_W-1:0]     quot
);

    logic [pbr_pkg::FS_W-1:0]      rem_reg, rem_next;
    logic [pbr_pkg::PERIOD_W-1:0]  q_reg, q_next;
    logic [pbr_pkg::FS_W-1:0]      dvs_reg, dvs_next;
    logic [pbr_pkg::DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                          busy_reg, busy_next;
    logic                          done_reg, done_next;
    logic [pbr_pkg::FS_W:0]        rem_shift;
    logic [pbr_pkg::FS_W:0]        rem_sub;
    logic                          fits;

    // one trial subtract per cycle
    always_comb
    begin
        rem_shift = {rem_reg, q_reg[pbr_pkg::PERIOD_W-1]};
        rem_sub   = rem_shift - {1'b0, dvs_reg};
        fits      = (rem_shift >= {1'b0, dvs_reg});
    end

    // sequencing of the iterations
    always_comb
    begin
        rem_next  = rem_reg;
        q_next    = q_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (cmd.go)
        begin
            rem_next  = cmd.rem_init;
            q_next    = cmd.dividend;
            dvs_next  = cmd.divisor;
            cnt_next  = cmd.steps;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? rem_sub[pbr_pkg::FS_W-1:0] : rem_shift[pbr_pkg::FS_W-1:0];
            q_next   = {q_reg[pbr_pkg::PERIOD_W-2:0], fits};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == 1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        q_reg   <= q_next;
        dvs_reg <= dvs_next;
    end

    assign done = done_reg;
    assign quot = q_reg;

endmodule

// File: hw/rtl/pbr_duty_ram.sv
// duty table memory, one write port and one registered read port
// depends on pbr_pkg for the default sizes
module pbr_duty_ram #(
    parameter int LEVELS    = pbr_pkg::LEVELS_DEF,
    parameter int DUTY_BITS = pbr_pkg::DUTY_BITS_DEF
) (
    input  logic                      clk,
    input  logic                      we,
    input  logic [$clog2(LEVELS)-1:0] waddr,
    input  logic [DUTY_BITS-1:0]      wdata,
    input  logic [$clog2(LEVELS)-1:0] raddr,
    output logic [DUTY_BITS-1:0]      rdata
);

    logic [DUTY_BITS-1:0] mem [LEVELS];
    logic [DUTY_BITS-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: hw/rtl/pwm_brightness_ramp.sv
// a start that changes the level first runs the shared divider 16 steps for the step delay;
// every item then runs it 20 steps for the pulse width unless the duty saturates
// one item at a time: next beat accepted the cycle after the result is loaded
// reset (async, active low) clears level, ramp state and registers; duty table unset
// top level of the pwm brightness ramp; uses pbr_pkg, pbr_div, pbr_duty_ram and macros
module pwm_brightness_ramp #(
    parameter int LEVELS    = pbr_pkg::LEVELS_DEF,
    parameter int DUTY_BITS = pbr_pkg::DUTY_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // configuration
    input  logic                              cfg_we,
    input  logic                              cfg_index,
    input  logic [pbr_pkg::PERIOD_W-1:0]      cfg_data,
    // request channel
    input  logic                              req_valid,
    output logic                              req_stall,
    input  logic [2:0]                        cmd,
    input  logic [pbr_pkg::LVL_W-1:0]         level,
    input  logic [pbr_pkg::DUR_W-1:0]         ramp_time,
    input  logic [pbr_pkg::FS_W-1:0]          duty_value,
    // response channel
    output logic                              rsp_valid,
    input  logic                              rsp_stall,
    output logic [pbr_pkg::LVL_W-1:0]         brightness,
    output logic [pbr_pkg::PERIOD_W-1:0]      pulse_width,
    output logic                              ramp_on
);

    localparam int AW = $clog2(LEVELS);
    localparam logic [pbr_pkg::LVL_W-1:0] LVL_MAX = pbr_pkg::LVL_W'(LEVELS - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIVQ,
        S_RD,
        S_MUL,
        S_PLAUNCH,
        S_PDIV,
        S_OUT
    } state_t;

    state_t                         state_reg, state_next;
    logic [pbr_pkg::LVL_W-1:0]      cur_reg, cur_next;
    logic [pbr_pkg::LVL_W-1:0]      tgt_reg, tgt_next;
    logic                           active_reg, active_next;
    logic                           up_reg, up_next;
    logic [pbr_pkg::DUR_W-1:0]      step_reg, step_next;
    logic [pbr_pkg::DUR_W-1:0]      cnt_reg, cnt_next;
    logic [pbr_pkg::PERIOD_W-1:0]   period_reg;
    logic [pbr_pkg::FS_W-1:0]       fs_reg;
    logic [pbr_pkg::PROD_W-1:0]     prod_reg, prod_next;
    logic                           sat_reg, sat_next;
    logic [pbr_pkg::PERIOD_W-1:0]   pulse_reg, pulse_next;
    logic                           rsp_valid_reg, rsp_valid_next;
    logic [pbr_pkg::LVL_W-1:0]      bright_reg, bright_next;
    logic [pbr_pkg::PERIOD_W-1:0]   pulse_out_reg, pulse_out_next;
    logic                           ract_reg, ract_next;

    logic [pbr_pkg::LVL_W-1:0]      lvl_c;
    logic [pbr_pkg::LVL_W-1:0]      lvl_gap;
    logic [pbr_pkg::LVL_W-1:0]      stepped;
    logic [pbr_pkg::FS_W-1:0]       fs_eff;
    logic [pbr_pkg::FS_W-1:0]       duty16;
    logic [pbr_pkg::DUR_W-1:0]      delay_q;
    logic                           mem_we;
    logic [DUTY_BITS-1:0]           mem_rdata;
    pbr_pkg::div_cmd_t              div_cmd;
    logic                           div_done;
    logic [pbr_pkg::PERIOD_W-1:0]   div_quot;

    // shared divider
    pbr_div u_div (
        .clk  (clk),
        .rst_n(rst_n),
        .cmd  (div_cmd),
        .done (div_done),
        .quot (div_quot)
    );

    // duty table
    pbr_duty_ram #(
        .LEVELS   (LEVELS),
        .DUTY_BITS(DUTY_BITS)
    ) u_ram (
        .clk  (clk),
        .we   (mem_we),
        .waddr(lvl_c[AW-1:0]),
        .wdata(duty_value[DUTY_BITS-1:0]),
        .raddr(cur_reg[AW-1:0]),
        .rdata(mem_rdata)
    );

    // operand preparation
    always_comb
    begin
        lvl_c   = (level > LVL_MAX) ? LVL_MAX : level;
        lvl_gap = (lvl_c > cur_reg) ? (lvl_c - cur_reg) : (cur_reg - lvl_c);
        fs_eff  = (fs_reg == '0) ? pbr_pkg::FS_W'(1) : fs_reg;
        duty16  = pbr_pkg::FS_W'(mem_rdata);
        delay_q = div_quot[pbr_pkg::DUR_W-1:0];
        if (up_reg)
        begin
            stepped = (cur_reg < tgt_reg) ? (cur_reg + 1'b1) : cur_reg;
        end
        else
        begin
            stepped = (cur_reg > tgt_reg) ? (cur_reg - 1'b1) : cur_reg;
        end
    end

    assign req_stall = (state_reg != S_IDLE);

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        cur_next       = cur_reg;
        tgt_next       = tgt_reg;
        active_next    = active_reg;
        up_next        = up_reg;
        step_next      = step_reg;
        cnt_next       = cnt_reg;
        prod_next      = prod_reg;
        sat_next       = sat_reg;
        pulse_next     = pulse_reg;
        bright_next    = bright_reg;
        pulse_out_next = pulse_out_reg;
        ract_next      = ract_reg;
        rsp_valid_next = rsp_valid_reg;
        mem_we         = 1'b0;
        div_cmd        = '0;

        // response beat taken
        if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = S_RD;
                    case (cmd)
                        pbr_pkg::CMD_TICK:
                        begin
                            if (active_reg)
                            begin
                                if (cnt_reg > 16'd1)
                                begin
                                    cnt_next = cnt_reg - 1'b1;
                                end
                                else
                                begin
                                    cur_next = stepped;
                                    cnt_next = step_reg;
                                    if (stepped == tgt_reg)
                                    begin
                                        active_next = 1'b0;
                                    end
                                end
                            end
                        end
                        pbr_pkg::CMD_START:
                        begin
                            tgt_next = lvl_c;
                            if (lvl_gap == '0)
                            begin
                                active_next = 1'b0;
                            end
                            else
                            begin
                                up_next          = (lvl_c > cur_reg);
                                div_cmd.go       = 1'b1;
                                div_cmd.rem_init = '0;
                                div_cmd.dividend = {ramp_time,
                                    {(pbr_pkg::PERIOD_W - pbr_pkg::DUR_W){1'b0}}};
                                div_cmd.divisor  = pbr_pkg::FS_W'(lvl_gap);
                                div_cmd.steps    = pbr_pkg::DELAY_STEPS;
                                state_next       = S_DIVQ;
                            end
                        end
                        pbr_pkg::CMD_STOP:
                        begin
                            if (active_reg)
                            begin
                                cur_next    = tgt_reg;
                                active_next = 1'b0;
                            end
                        end
                        pbr_pkg::CMD_SET:
                        begin
                            cur_next    = lvl_c;
                            active_next = 1'b0;
                        end
                        pbr_pkg::CMD_WRITE:
                        begin
                            mem_we = 1'b1;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_DIVQ:
            begin
                // step delay ready, at least one tick
                if (div_done)
                begin
                    step_next   = (delay_q == '0) ? 16'd1 : delay_q;
                    cnt_next    = (delay_q == '0) ? 16'd1 : delay_q;
                    active_next = 1'b1;
                    state_next  = S_RD;
                end
            end
            S_RD:
            begin
                state_next = S_MUL;
            end
            S_MUL:
            begin
                prod_next  = pbr_pkg::PROD_W'(duty16) * pbr_pkg::PROD_W'(period_reg);
                sat_next   = (duty16 >= fs_eff);
                state_next = S_PLAUNCH;
            end
            S_PLAUNCH:
            begin
                // duty at or above full scale gives the whole period
                if (sat_reg)
                begin
                    pulse_next = period_reg;
                    state_next = S_OUT;
                end
                else
                begin
                    div_cmd.go       = 1'b1;
                    div_cmd.rem_init = prod_reg[pbr_pkg::PROD_W-1:pbr_pkg::PERIOD_W];
                    div_cmd.dividend = prod_reg[pbr_pkg::PERIOD_W-1:0];
                    div_cmd.divisor  = fs_eff;
                    div_cmd.steps    = pbr_pkg::PULSE_STEPS;
                    state_next       = S_PDIV;
                end
            end
            S_PDIV:
            begin
                if (div_done)
                begin
                    pulse_next = div_quot;
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                // load the output register once the previous beat is gone
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    bright_next    = cur_reg;
                    pulse_out_next = pulse_reg;
                    ract_next      = active_reg;
                    rsp_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state, ramp registers and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cur_reg       <= '0;
            tgt_reg       <= '0;
            active_reg    <= 1'b0;
            up_reg        <= 1'b0;
            step_reg      <= 16'd1;
            cnt_reg       <= '0;
            prod_reg      <= '0;
            sat_reg       <= 1'b0;
            pulse_reg     <= '0;
            rsp_valid_reg <= 1'b0;
            bright_reg    <= '0;
            pulse_out_reg <= '0;
            ract_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cur_reg       <= cur_next;
            tgt_reg       <= tgt_next;
            active_reg    <= active_next;
            up_reg        <= up_next;
            step_reg      <= step_next;
            cnt_reg       <= cnt_next;
            prod_reg      <= prod_next;
            sat_reg       <= sat_next;
            pulse_reg     <= pulse_next;
            rsp_valid_reg <= rsp_valid_next;
            bright_reg    <= bright_next;
            pulse_out_reg <= pulse_out_next;
            ract_reg      <= ract_next;
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg <= pbr_pkg::PERIOD_RESET;
            fs_reg     <= pbr_pkg::FS_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                pbr_pkg::CFG_PERIOD:     period_reg <= cfg_data;
                pbr_pkg::CFG_FULL_SCALE: fs_reg     <= cfg_data[pbr_pkg::FS_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    assign rsp_valid   = rsp_valid_reg;
    assign brightness  = bright_reg;
    assign pulse_width = pulse_out_reg;
    assign ramp_on     = ract_reg;

    // checks
    `include "pwm_brightness_ramp_macros.svh"

    `PBR_ASSERT_IMPL(a_ramp_has_distance, active_reg, cur_reg != tgt_reg)
    `PBR_ASSERT(a_step_delay_nonzero, step_reg != '0)
    `PBR_ASSERT_IMPL(a_div_done_expected, div_done, state_reg == S_DIVQ || state_reg == S_PDIV)

endmodule

// File: test/pbr_checker.sv
// fade predictor and response checker for the pwm brightness ramp block
// watches the config port and both beat channels; depends on pbr_pkg only
module pbr_checker
    import pbr_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic                cfg_index,
    input  logic [PERIOD_W-1:0] cfg_data,
    input  logic                req_valid,
    input  logic                req_stall,
    input  logic [2:0]          cmd,
    input  logic [LVL_W-1:0]    level,
    input  logic [DUR_W-1:0]    ramp_time,
    input  logic [FS_W-1:0]     duty_value,
    input  logic                rsp_valid,
    input  logic                rsp_stall,
    input  logic [LVL_W-1:0]    brightness,
    input  logic [PERIOD_W-1:0] pulse_width,
    input  logic                ramp_on,
    output int                  fail_count,
    output int                  pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TABLE_DEPTH = 1 << LVL_W;

    typedef struct packed {
        logic [2:0]       op;
        logic [LVL_W-1:0] lvl;
        logic [DUR_W-1:0] dur;
        logic [FS_W-1:0]  duty;
    } fade_req_t;

    typedef struct packed {
        logic [LVL_W-1:0]    lvl;
        logic [PERIOD_W-1:0] pulse;
        logic                active;
    } fade_out_t;

    // predicted block state and register copies
    logic [PERIOD_W-1:0] period_reg;
    logic [FS_W-1:0]     full_scale_reg;
    logic [LVL_W-1:0]    lvl_now;
    logic [LVL_W-1:0]    lvl_goal;
    logic                ramping;
    logic                rising;
    logic [DUR_W-1:0]    step_ms;
    logic [DUR_W-1:0]    countdown;
    logic [FS_W-1:0]     duty_mem [TABLE_DEPTH];
    fade_out_t           fade_results_q [$];

    // pulse width of a level through the duty table, capped at one period
    function automatic logic [PERIOD_W-1:0] pulse_for(logic [LVL_W-1:0] l);
        logic [63:0] prod;
        logic [63:0] denom;
        prod  = 64'(duty_mem[l]) * 64'(period_reg);
        denom = (full_scale_reg == '0) ? 64'd1 : 64'(full_scale_reg);
        prod  = prod / denom;
        if (prod > 64'(period_reg))
            prod = 64'(period_reg);
        return prod[PERIOD_W-1:0];
    endfunction

    // apply one request beat to the predicted state and report the outcome
    function automatic fade_out_t apply_fade_cmd(fade_req_t r);
        int        span;
        int        dly;
        fade_out_t o;
        case (r.op)
            CMD_TICK:
            begin
                if (ramping)
                begin
                    if (countdown > 1)
                        countdown = countdown - 1'b1;
                    else
                    begin
                        if (rising && lvl_now < lvl_goal)
                            lvl_now = lvl_now + 1'b1;
                        else if (!rising && lvl_now > lvl_goal)
                            lvl_now = lvl_now - 1'b1;
                        countdown = step_ms;
                        if (lvl_now == lvl_goal)
                            ramping = 1'b0;
                    end
                end
            end
            CMD_START:
            begin
                span = (r.lvl > lvl_now) ? int'(r.lvl) - int'(lvl_now)
                                         : int'(lvl_now) - int'(r.lvl);
                lvl_goal = r.lvl;
                if (span == 0)
                    ramping = 1'b0;
                else
                begin
                    dly = int'(r.dur) / span;
                    if (dly < 1)
                        dly = 1;
                    step_ms   = dly[DUR_W-1:0];
                    countdown = step_ms;
                    rising    = r.lvl > lvl_now;
                    ramping   = 1'b1;
                end
            end
            CMD_STOP:
            begin
                if (ramping)
                begin
                    lvl_now = lvl_goal;
                    ramping = 1'b0;
                end
            end
            CMD_SET:
            begin
                lvl_now = r.lvl;
                ramping = 1'b0;
            end
            CMD_WRITE:
            begin
                duty_mem[r.lvl] = r.duty;
            end
            default:
            begin
                // unused codes leave the state alone
            end
        endcase
        o.lvl    = lvl_now;
        o.pulse  = pulse_for(lvl_now);
        o.active = ramping;
        return o;
    endfunction

    // register copies, prediction on request beats, compare on response beats
    always @(posedge clk or negedge rst_n)
    begin
        fade_req_t req;
        fade_out_t got;
        fade_out_t want;
        int        errs;
        if (!rst_n)
        begin
            period_reg     = PERIOD_RESET;
            full_scale_reg = FS_RESET;
            lvl_now        = '0;
            lvl_goal       = '0;
            ramping        = 1'b0;
            rising         = 1'b0;
            step_ms        = 16'd1;
            countdown      = '0;
            for (int k = 0; k < TABLE_DEPTH; k++)
                duty_mem[k] = '0;
            fade_results_q.delete();
            fail_count <= 0;
            pending    <= 0;
        end
        else
        begin
            errs = 0;
            if (cfg_we)
            begin
                if (cfg_index == CFG_PERIOD)
                    period_reg = cfg_data;
                else
                    full_scale_reg = cfg_data[FS_W-1:0];
            end

            // response beat against the oldest expectation
            if (rsp_valid && !rsp_stall)
            begin
                got.lvl    = brightness;
                got.pulse  = pulse_width;
                got.active = ramp_on;
                if (fade_results_q.size() == 0)
                begin
                    $error("response beat with no expectation pending");
                    errs++;
                end
                else
                begin
                    want = fade_results_q.pop_front();
                    if (got.lvl !== want.lvl)
                    begin
                        $error("brightness: expected %0d, actual %0d", want.lvl, got.lvl);
                        errs++;
                    end
                    if (got.pulse !== want.pulse)
                    begin
                        $error("pulse_width: expected %0d, actual %0d",
                               want.pulse, got.pulse);
                        errs++;
                    end
                    if (got.active !== want.active)
                    begin
                        $error("ramp_on: expected %0d, actual %0d",
                               want.active, got.active);
                        errs++;
                    end
                end
            end

            // request beat: predict its result
            if (req_valid && !req_stall)
            begin
                req.op   = cmd;
                req.lvl  = level;
                req.dur  = ramp_time;
                req.duty = duty_value;
                fade_results_q.push_back(apply_fade_cmd(req));
            end

            fail_count <= fail_count + errs;
            pending    <= fade_results_q.size();
        end
    end

endmodule

// File: test/testbench.sv
// top of the pwm brightness ramp testbench: clock, reset, stimulus and verdict
// depends on pbr_pkg, pwm_brightness_ramp and pbr_checker
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import pbr_pkg::*;

    localparam int TABLE_DEPTH     = 1 << LVL_W;
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int SETTLE_CYCLES   = 60;
    localparam int ITEMS_PER_PHASE = 67;
    localparam int RANDOM_PHASES   = 6;
    localparam logic [2:0] CMD_UNUSED_LO = CMD_WRITE + 3'd1;
    localparam logic [2:0] CMD_UNUSED_HI = 3'd7;

    logic                clk;
    logic                rst_n;
    logic                cfg_we;
    logic                cfg_index;
    logic [PERIOD_W-1:0] cfg_data;
    logic                req_valid;
    logic                req_stall;
    logic [2:0]          cmd;
    logic [LVL_W-1:0]    level;
    logic [DUR_W-1:0]    ramp_time;
    logic [FS_W-1:0]     duty_value;
    logic                rsp_valid;
    logic                rsp_stall;
    logic [LVL_W-1:0]    brightness;
    logic [PERIOD_W-1:0] pulse_width;
    logic                ramp_on;
    int                  fail_count;
    int                  pending;
    int                  idle_cycles = 0;

    // stimulus bookkeeping: loaded table entries and the span of levels reachable
    bit written [TABLE_DEPTH];
    int span_lo;
    int span_hi;
    int calm_left;
    int beats_sent;

    pwm_brightness_ramp u_top (.*);

    pbr_checker u_chk (.*);

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // gap length: mostly short, now and then long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [FS_W-1:0] pick_duty();
        int r;
        r = $urandom_range(0, 99);
        if (r < 15)
            return '0;
        if (r < 25)
            return '1;
        if (r < 45)
            return FS_W'($urandom_range(1, 15));
        return FS_W'($urandom_range(0, 65535));
    endfunction

    function automatic logic [DUR_W-1:0] pick_duration();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return DUR_W'($urandom_range(0, 40));
        if (r < 85)
            return DUR_W'($urandom_range(0, 1000));
        return DUR_W'($urandom_range(0, 65535));
    endfunction

    // contiguous run of loaded entries around the current span
    task automatic find_region(output int lo, output int hi);
        lo = span_lo;
        hi = span_hi;
        while (lo > 0 && written[lo-1])
            lo--;
        while (hi < TABLE_DEPTH - 1 && written[hi+1])
            hi++;
    endtask

    // one request beat: optional gap, then hold until accepted
    task automatic send_beat(logic [2:0] op, logic [LVL_W-1:0] lv,
                             logic [DUR_W-1:0] dur, logic [FS_W-1:0] dv);
        int gap;
        if (calm_left > 0)
        begin
            gap = 0;
            calm_left--;
        end
        else
        begin
            if ($urandom_range(0, 99) < 3)
                calm_left = $urandom_range(10, 30);
            gap = pick_gap();
        end
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid   <= 1'b1;
        cmd         <= op;
        level       <= lv;
        ramp_time   <= dur;
        duty_value  <= dv;
        do
            @(posedge clk);
        while (req_stall);
        beats_sent++;
    endtask

    task automatic put_duty(logic [LVL_W-1:0] idx, logic [FS_W-1:0] dv);
        send_beat(CMD_WRITE, idx, DUR_W'($urandom()), dv);
        written[idx] = 1'b1;
    endtask

    task automatic jump_to(logic [LVL_W-1:0] lv);
        send_beat(CMD_SET, lv, DUR_W'($urandom()), FS_W'($urandom()));
        span_lo = int'(lv);
        span_hi = int'(lv);
    endtask

    task automatic ramp_to(logic [LVL_W-1:0] lv, logic [DUR_W-1:0] dur);
        send_beat(CMD_START, lv, dur, FS_W'($urandom()));
        if (int'(lv) < span_lo)
            span_lo = int'(lv);
        if (int'(lv) > span_hi)
            span_hi = int'(lv);
    endtask

    task automatic tick_beat();
        send_beat(CMD_TICK, LVL_W'($urandom()), DUR_W'($urandom()), FS_W'($urandom()));
    endtask

    task automatic stop_beat();
        send_beat(CMD_STOP, LVL_W'($urandom()), DUR_W'($urandom()), FS_W'($urandom()));
    endtask

    // lower valid and wait until every predicted result has been returned
    task automatic wait_drained();
        req_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    task automatic set_regs(logic [PERIOD_W-1:0] per, logic [PERIOD_W-1:0] fs);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_PERIOD;
        cfg_data  <= per;
        @(posedge clk);
        cfg_index <= CFG_FULL_SCALE;
        cfg_data  <= fs;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // one random step; a start is always followed by a run of ticks
    task automatic random_item();
        int r;
        int lo;
        int hi;
        int lv;
        r = $urandom_range(0, 99);
        find_region(lo, hi);
        if (r < 38)
            tick_beat();
        else if (r < 54)
        begin
            if ($urandom_range(0, 1) == 0)
            begin
                lo = (span_lo - 6 > lo) ? span_lo - 6 : lo;
                hi = (span_hi + 6 < hi) ? span_hi + 6 : hi;
            end
            ramp_to(LVL_W'($urandom_range(lo, hi)), pick_duration());
            repeat ($urandom_range(1, 12))
                tick_beat();
        end
        else if (r < 61)
            stop_beat();
        else if (r < 69)
        begin
            lv = $urandom_range(0, TABLE_DEPTH - 1);
            if (!written[lv])
                lv = $urandom_range(lo, hi);
            jump_to(LVL_W'(lv));
        end
        else if (r < 94)
        begin
            // mostly grow the loaded run so ramps can reach further
            if ($urandom_range(0, 99) < 60 && (hi < TABLE_DEPTH - 1 || lo > 0))
            begin
                if (lo == 0 || (hi < TABLE_DEPTH - 1 && $urandom_range(0, 1) == 0))
                    lv = hi + 1;
                else
                    lv = lo - 1;
            end
            else
                lv = $urandom_range(0, TABLE_DEPTH - 1);
            put_duty(LVL_W'(lv), pick_duty());
        end
        else
            send_beat(3'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI)),
                      LVL_W'($urandom()), DUR_W'($urandom()), FS_W'($urandom()));
        if ($urandom_range(0, 99) < 3)
            wait_drained();
    endtask

    // response stall pattern: free runs, random stalls, occasional long free stretch
    initial
    begin
        int gap;
        rsp_stall <= 1'b0;
        forever
        begin
            rsp_stall <= 1'b0;
            if ($urandom_range(0, 99) < 5)
                repeat ($urandom_range(20, 60)) @(posedge clk);
            else
            begin
                repeat ($urandom_range(1, 6)) @(posedge clk);
                gap = pick_gap();
                if (gap > 0)
                begin
                    rsp_stall <= 1'b1;
                    repeat (gap) @(posedge clk);
                end
            end
        end
    end

    // watchdog on cycles with no beat on either channel
    always @(posedge clk)
    begin
        if (!rst_n || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // reset, directed sequence, random phases, verdict
    initial
    begin
        int goal;
        rst_n       <= 1'b0;
        cfg_we      <= 1'b0;
        cfg_index   <= CFG_PERIOD;
        cfg_data    <= '0;
        req_valid   <= 1'b0;
        cmd         <= CMD_TICK;
        level       <= '0;
        ramp_time   <= '0;
        duty_value  <= '0;
        span_lo     = 0;
        span_hi     = 0;
        calm_left   = 0;
        beats_sent  = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        set_regs(PERIOD_RESET, PERIOD_W'(FS_RESET));

        // directed: table extremes, every command, the corner cases of a ramp
        put_duty(8'd0, 16'd0);
        put_duty(8'd255, 16'hFFFF);
        jump_to(8'd255);
        jump_to(8'd0);
        put_duty(8'd1, 16'h8000);
        put_duty(8'd2, 16'h5555);
        put_duty(8'd3, 16'h0001);
        ramp_to(8'd3, 16'd0);        // zero duration floors the step delay at one tick
        repeat (3) tick_beat();
        tick_beat();                 // tick with no ramp running
        stop_beat();                 // stop with no ramp running
        ramp_to(8'd3, 16'd100);      // start at the current level
        ramp_to(8'd0, 16'hFFFF);     // longest ramp duration
        tick_beat();
        ramp_to(8'd1, 16'd2);        // restart while a ramp is running
        tick_beat();
        stop_beat();                 // jump to target
        ramp_to(8'd3, 16'd6);
        tick_beat();
        jump_to(8'd2);               // set cancels the ramp
        send_beat(CMD_UNUSED_LO, 8'hFF, 16'hFFFF, 16'hFFFF);
        send_beat(CMD_UNUSED_LO + 3'd1, 8'hAA, 16'h5555, 16'hAAAA);
        send_beat(CMD_UNUSED_HI, 8'h55, 16'hAAAA, 16'h5555);

        // random phases over register settings, extremes included
        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            wait_drained();
            case (ph)
                0: set_regs(20'd1, 20'd1);
                1: set_regs(20'd1000000, 20'd65535);
                2: set_regs(20'd1000000, 20'd1);
                3: set_regs(PERIOD_W'($urandom_range(1, 1000000)), 20'd0);
                4: set_regs(PERIOD_W'($urandom_range(1, 1000000)),
                            PERIOD_W'($urandom_range(1, 65535)));
                default: set_regs(PERIOD_RESET, PERIOD_W'($urandom_range(1, 4096)));
            endcase
            goal = beats_sent + ITEMS_PER_PHASE;
            while (beats_sent < goal)
                random_item();
        end

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
